[design/prra_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package prra_pkg;

    // Default sizing of the signal table.
    localparam int SIGNAL_SLOTS_DEF       = 32;
    localparam int FIRST_SIGNAL_INDEX_DEF = 1;
    localparam int GC_SIGNAL_INDEX_DEF    = 31;

    // Fixed field widths.
    localparam int IDX_W      = 5;
    localparam int GEN_W      = 4;
    localparam int CODE_W     = 5;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GC_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GC_THRESH = 1'b1;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_ARRIVE = 2'd0,
        REQ_GC     = 2'd1,
        REQ_CHOOSE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_code_t;

    // Request beat.
    typedef struct packed {
        req_code_t          req_type;
        logic [IDX_W-1:0]   signal_index;
        logic [GEN_W-1:0]   generations;
        logic               in_ml_code;
        logic               in_handler;
    } req_t;

    // Result beat.
    typedef struct packed {
        logic               handler_pending;
        logic               found;
        logic [CODE_W-1:0]  chosen_code;
        logic [COUNT_W-1:0] chosen_count;
    } rsp_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INC,
        ST_SCAN,
        ST_TAKE,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_item;
        logic clear_flag;
        logic inc;
        logic scan_adv;
        logic scan_read;
        logic take;
        logic load_out;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        req_code_t req_code;
        logic      evt_hit;
        logic      scan_hit;
        logic      scan_last;
        logic      out_free;
    } ctl_sts_t;

endpackage

`default_nettype wire

[design/prra_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module prra_ctrl
    import prra_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire ctl_sts_t sts,
    output ctl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // A request beat is taken only while the controller is idle.
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && (state_reg == ST_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (sts.req_code)
                        REQ_ARRIVE, REQ_GC: state_next = sts.evt_hit ? ST_INC : ST_DONE;
                        REQ_CHOOSE:         state_next = ST_SCAN;
                        REQ_CLEAR:          state_next = ST_DONE;
                    endcase
                end
            end
            ST_INC:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    state_next = ST_TAKE;
                end
                else if (sts.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_TAKE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take_item  = accept;
                cmd.clear_flag = accept && (sts.req_code == REQ_CLEAR);
            end
            ST_INC:
            begin
                cmd.inc = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan_read = sts.scan_hit;
                cmd.scan_adv  = !sts.scan_hit && !sts.scan_last;
            end
            ST_TAKE:
            begin
                cmd.take = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = sts.out_free;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/prra_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module prra_dp
    import prra_pkg::*;
#(
    parameter int SIGNAL_SLOTS       = SIGNAL_SLOTS_DEF,
    parameter int FIRST_SIGNAL_INDEX = FIRST_SIGNAL_INDEX_DEF,
    parameter int GC_SIGNAL_INDEX    = GC_SIGNAL_INDEX_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire req_t                  req,
    input  wire logic                  cfg_wr,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire ctl_cmd_t              cmd,
    output ctl_sts_t                   sts,
    output rsp_t                       rsp,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall
);

    localparam int IW = $clog2(SIGNAL_SLOTS);
    localparam int CW = 7;
    localparam logic GC_IN_RANGE = (GC_SIGNAL_INDEX < SIGNAL_SLOTS);
    localparam logic [IW-1:0] GC_SLOT    = IW'(GC_SIGNAL_INDEX);
    localparam logic [IW-1:0] FIRST_SLOT = IW'(FIRST_SIGNAL_INDEX);
    localparam logic [IW-1:0] LAST_STEP  = IW'(SIGNAL_SLOTS - 1);

    // Outstanding event count per slot; an entry without its valid bit reads as zero.
    logic [COUNT_W-1:0]      cnt_mem [SIGNAL_SLOTS];
    logic [SIGNAL_SLOTS-1:0] valid_reg;
    logic [SIGNAL_SLOTS-1:0] pend_reg;
    logic [COUNT_W-1:0]      rdata_reg;
    logic                    rvalid_reg;

    logic                    gc_en_reg;
    logic [GEN_W-1:0]        thresh_reg;

    logic                    in_ml_reg;
    logic                    in_hnd_reg;
    logic [IW-1:0]           slot_reg;
    logic [IW-1:0]           ptr_reg;
    logic [IW-1:0]           step_reg;
    logic [IW-1:0]           last_reg;
    logic [IW-1:0]           code_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic                    flag_reg;
    logic                    found_reg;
    logic                    rsp_valid_reg;
    rsp_t                    rsp_reg;

    logic [IW-1:0]           evt_slot;
    logic                    arrive_ok;
    logic                    gc_ok;
    logic                    rd_en;
    logic [IW-1:0]           rd_addr;
    logic [COUNT_W-1:0]      old_cnt;
    logic [COUNT_W-1:0]      inc_val;
    logic [IW-1:0]           ptr_adv;
    logic [IW-1:0]           last_adv;

    // Round-robin successor: wraps to the first signal index past the table end.
    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] cur);
        logic [IW:0] sum;
        sum = {1'b0, cur} + (IW + 1)'(1);
        if (sum >= (IW + 1)'(SIGNAL_SLOTS))
        begin
            return FIRST_SLOT;
        end
        return sum[IW-1:0];
    endfunction

    assign ptr_adv  = next_slot(ptr_reg);
    assign last_adv = next_slot(last_reg);

    // Qualification of arrivals and garbage-collection events.
    assign arrive_ok = (CW'(req.signal_index) >= CW'(FIRST_SIGNAL_INDEX))
                    && (CW'(req.signal_index) < CW'(SIGNAL_SLOTS));
    assign gc_ok     = GC_IN_RANGE && gc_en_reg && (req.generations >= thresh_reg)
                    && !(req.in_handler && (CW'(code_reg) == CW'(GC_SIGNAL_INDEX)));
    assign evt_slot  = (req.req_type == REQ_GC) ? GC_SLOT : IW'(req.signal_index);

    always_comb
    begin
        sts.req_code  = req.req_type;
        sts.evt_hit   = 1'b0;
        if (req.req_type == REQ_ARRIVE)
        begin
            sts.evt_hit = arrive_ok;
        end
        else if (req.req_type == REQ_GC)
        begin
            sts.evt_hit = gc_ok;
        end
        sts.scan_hit  = pend_reg[ptr_reg];
        sts.scan_last = (step_reg == LAST_STEP);
        sts.out_free  = !rsp_valid_reg || !rsp_stall;
    end

    // Memory port: one registered read, one write.
    assign rd_en   = cmd.take_item || cmd.scan_read;
    assign rd_addr = cmd.scan_read ? ptr_reg : evt_slot;
    assign old_cnt = rvalid_reg ? rdata_reg : '0;
    assign inc_val = old_cnt + COUNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg  <= cnt_mem[rd_addr];
            rvalid_reg <= valid_reg[rd_addr];
        end
        if (cmd.inc)
        begin
            cnt_mem[slot_reg] <= inc_val;
        end
    end

    // Valid and pending bits per slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            pend_reg  <= '0;
        end
        else if (cmd.inc)
        begin
            valid_reg[slot_reg] <= 1'b1;
            pend_reg[slot_reg]  <= (inc_val != '0);
        end
        else if (cmd.take)
        begin
            valid_reg[ptr_reg] <= 1'b0;
            pend_reg[ptr_reg]  <= 1'b0;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gc_en_reg  <= 1'b0;
            thresh_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_GC_ENABLE: gc_en_reg  <= cfg_data[0];
                CFG_GC_THRESH: thresh_reg <= cfg_data;
            endcase
        end
    end

    // Captured request fields and scan pointer.
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            in_ml_reg  <= req.in_ml_code;
            in_hnd_reg <= req.in_handler;
            slot_reg   <= evt_slot;
            ptr_reg    <= last_adv;
            step_reg   <= '0;
        end
        else if (cmd.scan_adv)
        begin
            ptr_reg  <= ptr_adv;
            step_reg <= step_reg + IW'(1);
        end
    end

    // Architectural state: current signal, last choice and handler-pending flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= '0;
            code_reg  <= '0;
            count_reg <= '0;
            flag_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take_item)
            begin
                found_reg <= 1'b0;
            end
            if (cmd.clear_flag)
            begin
                flag_reg <= 1'b0;
            end
            if (cmd.inc && in_ml_reg && !flag_reg && !in_hnd_reg)
            begin
                flag_reg <= 1'b1;
            end
            if (cmd.take)
            begin
                last_reg  <= ptr_reg;
                code_reg  <= ptr_reg;
                count_reg <= old_cnt;
                found_reg <= 1'b1;
            end
        end
    end

    // Output register: holds a finished beat until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rsp_reg.handler_pending <= flag_reg;
            rsp_reg.found           <= found_reg;
            rsp_reg.chosen_code     <= CODE_W'(code_reg);
            rsp_reg.chosen_count    <= count_reg;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

[design/pending_signal_round_robin_arbiter_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// req       in         req_valid / req_stall      req_t (one request per beat)
// rsp       out        rsp_valid / rsp_stall      rsp_t (one result per request)
// cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A counted arrival or GC event passes through ST_INC on its way to ST_DONE; an ignored
// one or a clear goes straight to ST_DONE.
// A choose passes through ST_SCAN: the scan looks at one slot per cycle
// against the pending bits, then reads the chosen count from the slot memory.
// Reset clears the valid and pending bits at once; there is no clearing pass.
// A result waiting under rsp_stall lets the next request in, which then holds in its
// final state until the output register is free.

module pending_signal_round_robin_arbiter_top
    import prra_pkg::*;
#(
    parameter int SIGNAL_SLOTS       = SIGNAL_SLOTS_DEF,
    parameter int FIRST_SIGNAL_INDEX = FIRST_SIGNAL_INDEX_DEF,
    parameter int GC_SIGNAL_INDEX    = GC_SIGNAL_INDEX_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire req_t                  req,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output rsp_t                       rsp,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    prra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    prra_dp #(
        .SIGNAL_SLOTS       (SIGNAL_SLOTS),
        .FIRST_SIGNAL_INDEX (FIRST_SIGNAL_INDEX),
        .GC_SIGNAL_INDEX    (GC_SIGNAL_INDEX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

`ifndef SYNTHESIS
    // At most one datapath action other than the flag clear is commanded in any cycle.
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take_item, cmd.inc, cmd.scan_adv, cmd.scan_read, cmd.take,
                  cmd.load_out}))
        else $error("conflicting datapath commands");

    // Marking a slot handled always follows the memory read of that slot.
    a_take_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> $past(cmd.scan_read))
        else $error("slot taken without a preceding read");

    // Loading the output register presents a result beat in the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> rsp_valid)
        else $error("result beat lost after load");

    // A choose request always occupies the block for at least the scan cycle.
    a_choose_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req.req_type == REQ_CHOOSE)) |=> req_stall)
        else $error("choose request did not start a scan");
`endif

endmodule

`default_nettype wire
